[rtl/bmm_pkg.sv]
`timescale 1ns / 1ps

package bmm_pkg;

    localparam int RowSlots        = 32;
    localparam int VertW           = 5;
    localparam int ColW            = 6;
    localparam int CountW          = 6;
    localparam int EdgeW           = 32;
    localparam int MaxVertsDefault = 32;
    localparam int CfgIdxW         = 1;
    localparam int CfgW            = 6;
    localparam int SDataW          = 40;
    localparam int MDataW          = 24;
    localparam int ResultW         = 17;

    typedef enum logic [CfgIdxW-1:0] {
        CFG_LEFT_COUNT  = 1'b0,
        CFG_RIGHT_COUNT = 1'b1
    } cfg_reg_t;

    typedef struct packed {
        logic [VertW-1:0] vertex;
        logic [ColW-1:0]  next_col;
    } frame_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_ROOT,
        ST_SCAN,
        ST_DECIDE,
        ST_POP_WAIT,
        ST_POP_LOAD,
        ST_FLIP_WAIT,
        ST_FLIP_WRITE,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic load_row;
        logic run_init;
        logic root_init;
        logic scan;
        logic mark;
        logic match_top;
        logic push;
        logic pop;
        logic load_top;
        logic flip_write;
        logic next_root;
        logic count_pair;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic root_done;
        logic found;
        logic col_taken;
        logic depth_one;
        logic depth_full;
        logic r_zero;
        logic out_done;
        logic slot_free;
    } status_t;

endpackage

[rtl/bmm_ctrl.sv]
`timescale 1ns / 1ps

module bmm_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    input  logic             s_tlast,
    output logic             s_tready,
    input  bmm_pkg::status_t status,
    output bmm_pkg::cmd_t    cmd
);

    bmm_pkg::state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= bmm_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            bmm_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load_row = 1'b1;
                    if (s_tlast) state_next = bmm_pkg::ST_CLEAR;
                end
            end
            bmm_pkg::ST_CLEAR: begin
                cmd.run_init = 1'b1;
                state_next   = bmm_pkg::ST_ROOT;
            end
            bmm_pkg::ST_ROOT: begin
                if (status.root_done) begin
                    state_next = bmm_pkg::ST_OUT;
                end else begin
                    cmd.root_init = 1'b1;
                    state_next    = bmm_pkg::ST_SCAN;
                end
            end
            bmm_pkg::ST_SCAN: begin
                cmd.scan   = 1'b1;
                state_next = bmm_pkg::ST_DECIDE;
            end
            bmm_pkg::ST_DECIDE: begin
                if (!status.found) begin
                    // dead end: drop this frame
                    if (status.depth_one) begin
                        cmd.next_root = 1'b1;
                        state_next    = bmm_pkg::ST_ROOT;
                    end else begin
                        cmd.pop    = 1'b1;
                        state_next = bmm_pkg::ST_POP_WAIT;
                    end
                end else begin
                    cmd.mark = 1'b1;
                    if (!status.col_taken) begin
                        // free column: augment back down the stack
                        cmd.match_top = 1'b1;
                        if (status.depth_one) begin
                            cmd.next_root  = 1'b1;
                            cmd.count_pair = 1'b1;
                            state_next     = bmm_pkg::ST_ROOT;
                        end else begin
                            cmd.pop    = 1'b1;
                            state_next = bmm_pkg::ST_FLIP_WAIT;
                        end
                    end else if (status.depth_full) begin
                        state_next = bmm_pkg::ST_SCAN;
                    end else begin
                        cmd.push   = 1'b1;
                        state_next = bmm_pkg::ST_SCAN;
                    end
                end
            end
            bmm_pkg::ST_POP_WAIT: begin
                state_next = bmm_pkg::ST_POP_LOAD;
            end
            bmm_pkg::ST_POP_LOAD: begin
                cmd.load_top = 1'b1;
                state_next   = bmm_pkg::ST_SCAN;
            end
            bmm_pkg::ST_FLIP_WAIT: begin
                state_next = bmm_pkg::ST_FLIP_WRITE;
            end
            bmm_pkg::ST_FLIP_WRITE: begin
                cmd.flip_write = 1'b1;
                if (status.depth_one) begin
                    cmd.next_root  = 1'b1;
                    cmd.count_pair = 1'b1;
                    state_next     = bmm_pkg::ST_ROOT;
                end else begin
                    cmd.pop    = 1'b1;
                    state_next = bmm_pkg::ST_FLIP_WAIT;
                end
            end
            bmm_pkg::ST_OUT: begin
                if (status.r_zero) begin
                    state_next = bmm_pkg::ST_IDLE;
                end else if (status.slot_free) begin
                    cmd.out_load = 1'b1;
                    if (status.out_done) state_next = bmm_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = bmm_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

[rtl/bmm_dp.sv]
`timescale 1ns / 1ps

module bmm_dp #(
    parameter int MAX_VERTS = bmm_pkg::MaxVertsDefault
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  bmm_pkg::cmd_t               cmd,
    output bmm_pkg::status_t            status,
    input  logic [bmm_pkg::VertW-1:0]   row_index,
    input  logic [bmm_pkg::EdgeW-1:0]   row_edges,
    input  logic                        cfg_we,
    input  bmm_pkg::cfg_reg_t           cfg_index,
    input  logic [bmm_pkg::CfgW-1:0]    cfg_wdata,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [bmm_pkg::MDataW-1:0]  m_tdata,
    output logic                        m_tlast
);

    localparam int AW  = (MAX_VERTS > 1) ? $clog2(MAX_VERTS) : 1;
    localparam int DW  = $clog2(MAX_VERTS + 1);
    localparam int LIM = (MAX_VERTS < bmm_pkg::RowSlots) ? MAX_VERTS : bmm_pkg::RowSlots;

    localparam int VW = bmm_pkg::VertW;
    localparam int CW = bmm_pkg::ColW;
    localparam int NW = bmm_pkg::CountW;
    localparam int EW = bmm_pkg::EdgeW;

    // adjacency rows and match table
    logic [EW-1:0]        edge_mem [bmm_pkg::RowSlots];
    logic [VW-1:0]        pl_reg   [bmm_pkg::RowSlots];
    logic [EW-1:0]        pv_reg;

    // search state
    bmm_pkg::frame_t      stk_mem [MAX_VERTS];
    bmm_pkg::frame_t      rd_reg;
    bmm_pkg::frame_t      top_reg;
    logic [EW-1:0]        seen_reg;
    logic [DW-1:0]        depth_reg;
    logic [NW-1:0]        u_reg;
    logic [NW-1:0]        pairs_reg;
    logic [VW-1:0]        col_reg;
    logic                 found_reg;
    logic [VW-1:0]        v_reg;

    logic [bmm_pkg::CfgW-1:0] left_cfg_reg, right_cfg_reg;

    logic                         m_valid_reg;
    logic [bmm_pkg::ResultW-1:0]  m_data_reg;
    logic                         m_last_reg;

    logic [NW-1:0]        left_n, right_n;
    logic [EW-1:0]        row_sel, col_mask, ge_mask, cand, low;
    logic [VW-1:0]        col_enc;
    logic                 cand_any;
    logic [AW-1:0]        stk_addr;
    logic [VW-1:0]        flip_col;
    logic [bmm_pkg::ResultW-1:0] result;

    assign left_n  = (left_cfg_reg  > NW'(LIM)) ? NW'(LIM) : left_cfg_reg;
    assign right_n = (right_cfg_reg > NW'(LIM)) ? NW'(LIM) : right_cfg_reg;

    assign row_sel  = edge_mem[top_reg.vertex];
    assign col_mask = right_n[VW] ? '1 : ((EW'(1) << right_n[VW-1:0]) - EW'(1));
    assign ge_mask  = top_reg.next_col[VW] ? '0 : ('1 << top_reg.next_col[VW-1:0]);
    assign cand     = row_sel & col_mask & ~seen_reg & ge_mask;
    // isolate the lowest candidate column
    assign low      = cand & (~cand + EW'(1));
    assign cand_any = |cand;

    always_comb begin
        col_enc = '0;
        for (int i = 0; i < EW; i++) begin
            if (low[i]) col_enc = col_enc | VW'(i);
        end
    end

    assign stk_addr = AW'(depth_reg - DW'(1));
    assign flip_col = VW'(rd_reg.next_col - CW'(1));

    assign status.root_done  = (u_reg >= left_n);
    assign status.found      = found_reg;
    assign status.col_taken  = pv_reg[col_reg];
    assign status.depth_one  = (depth_reg == DW'(1));
    assign status.depth_full = (depth_reg >= DW'(MAX_VERTS));
    assign status.r_zero     = (right_n == '0);
    assign status.out_done   = ({1'b0, v_reg} == (right_n - NW'(1)));
    assign status.slot_free  = !m_valid_reg || m_tready;

    // fields from the lowest bit: right_vertex, is_matched, partner_left, match_total
    assign result = {
        (status.out_done ? pairs_reg : NW'(0)),
        (pv_reg[v_reg] ? pl_reg[v_reg] : VW'(0)),
        pv_reg[v_reg],
        v_reg
    };

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            left_cfg_reg  <= bmm_pkg::CfgW'(bmm_pkg::RowSlots);
            right_cfg_reg <= bmm_pkg::CfgW'(bmm_pkg::RowSlots);
            pv_reg        <= '0;
            depth_reg     <= '0;
            pairs_reg     <= '0;
            u_reg         <= '0;
            v_reg         <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            if (cfg_we) begin
                unique case (cfg_index)
                    bmm_pkg::CFG_LEFT_COUNT:  left_cfg_reg  <= cfg_wdata;
                    bmm_pkg::CFG_RIGHT_COUNT: right_cfg_reg <= cfg_wdata;
                    default: ;
                endcase
            end
            if (cmd.run_init) begin
                pv_reg    <= '0;
                pairs_reg <= '0;
                u_reg     <= '0;
                v_reg     <= '0;
            end
            if (cmd.match_top)  pv_reg[col_reg]  <= 1'b1;
            if (cmd.flip_write) pv_reg[flip_col] <= 1'b1;
            if (cmd.root_init)  depth_reg <= DW'(1);
            if (cmd.push)       depth_reg <= depth_reg + DW'(1);
            if (cmd.pop)        depth_reg <= depth_reg - DW'(1);
            if (cmd.next_root)  u_reg <= u_reg + NW'(1);
            if (cmd.count_pair) pairs_reg <= pairs_reg + NW'(1);
            if (cmd.out_load) begin
                v_reg       <= v_reg + VW'(1);
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (cmd.load_row) edge_mem[row_index] <= row_edges;
        if (cmd.match_top)  pl_reg[col_reg]  <= top_reg.vertex;
        if (cmd.flip_write) pl_reg[flip_col] <= rd_reg.vertex;
        if (cmd.root_init) begin
            seen_reg         <= '0;
            top_reg.vertex   <= VW'(u_reg);
            top_reg.next_col <= '0;
        end
        if (cmd.scan) begin
            col_reg   <= col_enc;
            found_reg <= cand_any;
        end
        if (cmd.mark) begin
            seen_reg[col_reg] <= 1'b1;
            top_reg.next_col  <= {1'b0, col_reg} + CW'(1);
        end
        if (cmd.push) begin
            top_reg.vertex   <= pl_reg[col_reg];
            top_reg.next_col <= '0;
        end
        if (cmd.load_top) top_reg <= rd_reg;
        if (cmd.out_load) begin
            m_data_reg <= result;
            m_last_reg <= status.out_done;
        end
    end

    // frame stack, read port follows the current depth
    always_ff @(posedge aclk) begin
        if (cmd.push) begin
            stk_mem[stk_addr] <= '{vertex: top_reg.vertex, next_col: {1'b0, col_reg} + CW'(1)};
        end
        rd_reg <= stk_mem[stk_addr];
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {(bmm_pkg::MDataW - bmm_pkg::ResultW)'(0), m_data_reg};
    assign m_tlast  = m_last_reg;

endmodule

[rtl/bipartite_maximum_matching_top.sv]
`timescale 1ns / 1ps

// Maximum bipartite matching engine (augmenting paths, depth-first).
// Input stream: one word per adjacency row; the word with s_tlast high is
// stored and then starts a matching run over left_count x right_count.
// Rows 0..left_count-1 must have been loaded before a run.
// Output stream: one word per right vertex, ascending, m_tlast on the last
// one, which also carries the matching size.
// Config: cfg_we/cfg_index/cfg_wdata, index 0 left_count, 1 right_count;
// write only while the engine is idle.
// Throughput: rows are taken one per cycle while idle.
// A run first clears, then per left vertex starts a search, and each column
// search step is a scan then a decide; each stack frame popped or flipped
// passes a wait state before its load or write, since the stack read port is
// registered.
// Results then leave at one per cycle when m_tready stays high; a stall
// holds the output register and the engine waits, nothing is lost.
// s_tready is low from the last row until the last result is registered,
// or until the run ends when right_count is 0. Reset: synchronous, active low;
// counts go to 32, output is emptied, the match table reads as unmatched; stored rows are not cleared.
module bipartite_maximum_matching_top #(
    parameter int MAX_VERTS = bmm_pkg::MaxVertsDefault
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [bmm_pkg::SDataW-1:0]    s_tdata,   // row_index, row_edges
    input  logic                          s_tlast,   // run_after
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [bmm_pkg::MDataW-1:0]    m_tdata,   // right_vertex, is_matched, partner_left, match_total
    output logic                          m_tlast,   // last_result
    input  logic                          cfg_we,
    input  logic [bmm_pkg::CfgIdxW-1:0]   cfg_index,
    input  logic [bmm_pkg::CfgW-1:0]      cfg_wdata
);

    bmm_pkg::cmd_t    cmd;
    bmm_pkg::status_t status;

    bmm_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tlast  (s_tlast),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    bmm_dp #(
        .MAX_VERTS (MAX_VERTS)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .status    (status),
        .row_index (s_tdata[bmm_pkg::VertW-1:0]),
        .row_edges (s_tdata[bmm_pkg::VertW +: bmm_pkg::EdgeW]),
        .cfg_we    (cfg_we),
        .cfg_index (bmm_pkg::cfg_reg_t'(cfg_index)),
        .cfg_wdata (cfg_wdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

`ifndef SYNTHESIS
    a_reset_empties_output : assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output word valid right after reset");

    a_total_only_on_last : assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tlast |-> m_tdata[16:11] == 6'd0)
        else $error("match total on a word that is not the last");

    a_total_in_range : assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> m_tdata[16:11] <= 6'd32)
        else $error("match total out of range");

    a_unmatched_no_partner : assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[5] |-> m_tdata[10:6] == 5'd0)
        else $error("unmatched vertex carries a partner");

    a_no_load_while_searching : assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.scan || cmd.pop || cmd.flip_write |-> !s_tready)
        else $error("input taken during a matching run");
`endif

endmodule

[test/bmm_pairing_checker.sv]
`timescale 1ns / 1ps

module bmm_pairing_checker
    import bmm_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    input  logic                s_tready,
    input  logic [SDataW-1:0]   s_tdata,   // row_index, row_edges
    input  logic                s_tlast,   // run_after
    input  logic                m_tvalid,
    input  logic                m_tready,
    input  logic [MDataW-1:0]   m_tdata,   // right_vertex, is_matched, partner_left, match_total
    input  logic                m_tlast,   // last_result
    input  logic                cfg_we,
    input  logic [CfgIdxW-1:0]  cfg_index,
    input  logic [CfgW-1:0]     cfg_wdata,
    output int                  fail_count,
    output int                  pending_words
);

    localparam int              MaxVerts  = MaxVertsDefault;
    localparam logic [ColW-1:0] Unmatched = '1;
    localparam int              PrintCap  = 100;

    typedef struct packed {
        logic [VertW-1:0]  vertex;
        logic              matched;
        logic [VertW-1:0]  partner;
        logic [CountW-1:0] total;
        logic              last;
    } pairing_t;

    logic [EdgeW-1:0]  edge_store [RowSlots];
    logic [CountW-1:0] left_reg;
    logic [CountW-1:0] right_reg;
    pairing_t          pairing_q [$];

    task automatic report_mismatch(input string msg);
        if (fail_count < PrintCap) begin
            $display("%0t pairing error: %s", $time, msg);
        end
        fail_count++;
    endtask

    function automatic int clamp_vertices(input logic [CountW-1:0] c);
        int n;
        n = int'(c);
        if (n > RowSlots) n = RowSlots;
        if (n > MaxVerts) n = MaxVerts;
        return n;
    endfunction

    // augmenting-path matching over the stored rows, queues one word per right vertex
    task automatic predict_matching();
        int               lft;
        int               rgt;
        int               u;
        int               v;
        int               d;
        int               col;
        int               depth;
        int               total;
        bit               found;
        int               stk_vert [MaxVerts];
        int               stk_col [MaxVerts];
        logic [ColW-1:0]  owner [RowSlots];
        logic [EdgeW-1:0] seen;
        logic [EdgeW-1:0] col_mask;
        logic [EdgeW-1:0] row;
        pairing_t         w;
        lft = clamp_vertices(left_reg);
        rgt = clamp_vertices(right_reg);
        col_mask = (rgt >= EdgeW) ? '1 : ((32'd1 << rgt) - 32'd1);
        for (v = 0; v < RowSlots; v++) owner[v] = Unmatched;
        total = 0;
        for (u = 0; u < lft; u++) begin
            seen = '0;
            found = 1'b0;
            stk_vert[0] = u;
            stk_col[0] = 0;
            depth = 1;
            while (depth > 0 && !found) begin
                row = edge_store[stk_vert[depth-1]] & col_mask;
                col = stk_col[depth-1];
                while (col < rgt && !(row[col] && !seen[col])) col++;
                if (col >= rgt) begin
                    depth--;
                end else begin
                    seen[col] = 1'b1;
                    stk_col[depth-1] = col + 1;
                    if (owner[col] == Unmatched) begin
                        // every frame on the path takes the column it chose last
                        for (d = depth - 1; d >= 0; d--) begin
                            owner[stk_col[d]-1] = stk_vert[d][ColW-1:0];
                        end
                        found = 1'b1;
                    end else if (depth < MaxVerts) begin
                        stk_vert[depth] = int'(owner[col][VertW-1:0]);
                        stk_col[depth] = 0;
                        depth++;
                    end
                end
            end
            if (found) total++;
        end
        for (v = 0; v < rgt; v++) begin
            w.vertex  = v[VertW-1:0];
            w.matched = (owner[v] != Unmatched);
            w.partner = w.matched ? owner[v][VertW-1:0] : '0;
            w.last    = (v == rgt - 1);
            w.total   = w.last ? total[CountW-1:0] : '0;
            pairing_q.push_back(w);
        end
    endtask

    always @(posedge aclk) begin
        pairing_t got;
        pairing_t want;
        if (!aresetn) begin
            left_reg = 6'd32;
            right_reg = 6'd32;
            pairing_q.delete();
            fail_count = 0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    CFG_LEFT_COUNT:  left_reg = cfg_wdata;
                    CFG_RIGHT_COUNT: right_reg = cfg_wdata;
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                edge_store[s_tdata[VertW-1:0]] = s_tdata[VertW +: EdgeW];
                if (s_tlast) predict_matching();
            end
            if (m_tvalid && m_tready) begin
                got.vertex  = m_tdata[4:0];
                got.matched = m_tdata[5];
                got.partner = m_tdata[10:6];
                got.total   = m_tdata[16:11];
                got.last    = m_tlast;
                if (pairing_q.size() == 0) begin
                    report_mismatch($sformatf("unexpected word for right vertex %0d",
                                              got.vertex));
                end else begin
                    want = pairing_q.pop_front();
                    if (got.vertex !== want.vertex)
                        report_mismatch($sformatf("right_vertex %0d, expected %0d",
                                                  got.vertex, want.vertex));
                    if (got.matched !== want.matched)
                        report_mismatch($sformatf("vertex %0d is_matched %0b, expected %0b",
                                                  want.vertex, got.matched, want.matched));
                    if (got.partner !== want.partner)
                        report_mismatch($sformatf("vertex %0d partner_left %0d, expected %0d",
                                                  want.vertex, got.partner, want.partner));
                    if (got.total !== want.total)
                        report_mismatch($sformatf("vertex %0d match_total %0d, expected %0d",
                                                  want.vertex, got.total, want.total));
                    if (got.last !== want.last)
                        report_mismatch($sformatf("vertex %0d last_result %0b, expected %0b",
                                                  want.vertex, got.last, want.last));
                end
            end
        end
        pending_words = pairing_q.size();
    end

endmodule

[test/bipartite_maximum_matching_top_tb.sv]
`timescale 1ns / 1ps

module bipartite_maximum_matching_top_tb;
    import bmm_pkg::*;

    localparam int ItemTarget  = 400;
    localparam int DrainCycles = 4500;
    localparam int CycleLimit  = 2_000_000;

    logic                aclk;
    logic                aresetn;
    logic                s_tvalid;
    logic                s_tready;
    logic [SDataW-1:0]   s_tdata;   // row_index, row_edges
    logic                s_tlast;   // run_after
    logic                m_tvalid;
    logic                m_tready;
    logic [MDataW-1:0]   m_tdata;   // right_vertex, is_matched, partner_left, match_total
    logic                m_tlast;   // last_result
    logic                cfg_we;
    logic [CfgIdxW-1:0]  cfg_index;
    logic [CfgW-1:0]     cfg_wdata;

    int                  fail_count;
    int                  pending_words;
    int                  cycle_count = 0;
    int                  items_sent;
    int                  burst_left;
    logic [RowSlots-1:0] rows_written;
    logic [CountW-1:0]   left_set;
    logic [CountW-1:0]   right_set;

    bipartite_maximum_matching_top u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    bmm_pairing_checker u_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tlast       (s_tlast),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tlast       (m_tlast),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .fail_count    (fail_count),
        .pending_words (pending_words)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CycleLimit) begin
            $display("bipartite_maximum_matching_top: mismatch");
            $finish;
        end
    end

    // receiver: stretches of steady, patchy, mostly-ready and mostly-stalled acceptance
    initial begin
        int mode;
        int span;
        m_tready = 1'b0;
        forever begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(5, 60);
            repeat (span) begin
                @(negedge aclk);
                case (mode)
                    0:       m_tready = 1'b1;
                    1:       m_tready = 1'($urandom_range(0, 1));
                    2:       m_tready = ($urandom_range(0, 3) != 0);
                    default: m_tready = ($urandom_range(0, 7) == 0);
                endcase
            end
        end
    end

    function automatic int clamp_count(input logic [CountW-1:0] c);
        int n;
        n = int'(c);
        if (n > RowSlots) n = RowSlots;
        if (n > MaxVertsDefault) n = MaxVertsDefault;
        return n;
    endfunction

    function automatic logic [EdgeW-1:0] row_pattern(input int mode, input int u, input int rc);
        logic [EdgeW-1:0] cols;
        logic [EdgeW-1:0] bits;
        int               m;
        cols = (rc >= EdgeW) ? '1 : ((32'd1 << rc) - 32'd1);
        m = (mode == 6) ? $urandom_range(0, 5) : mode;
        case (m)
            0:       bits = $urandom;
            1:       bits = $urandom & $urandom & $urandom;
            2:       bits = 32'h3 << u;
            3:       bits = 32'd1 << $urandom_range(0, 2);
            4:       bits = ~($urandom & $urandom & $urandom);
            default: bits = (32'd1 << u) | (32'd1 << $urandom_range(0, 31));
        endcase
        // junk in the columns past right_count
        if ($urandom_range(0, 1)) bits = bits | ($urandom & ~cols);
        return bits;
    endfunction

    task automatic send_row(input logic [VertW-1:0] idx, input logic [EdgeW-1:0] edges,
                            input logic last);
        int gap;
        if (burst_left == 0) begin
            s_tvalid = 1'b0;
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 20) : $urandom_range(1, 4);
            repeat (gap) @(negedge aclk);
            burst_left = ($urandom_range(0, 5) == 0) ? 48 : $urandom_range(1, 10);
        end
        s_tvalid = 1'b1;
        s_tdata  = {{(SDataW-EdgeW-VertW){1'b0}}, edges, idx};
        s_tlast  = last;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
        rows_written[idx] = 1'b1;
        items_sent++;
        burst_left--;
    endtask

    // wait for every outstanding word, then let a run with no output finish
    task automatic drain_block();
        s_tvalid = 1'b0;
        while (pending_words != 0) @(negedge aclk);
        repeat (DrainCycles) @(negedge aclk);
    endtask

    task automatic write_count(input cfg_reg_t idx, input logic [CfgW-1:0] val);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_wdata = val;
        @(negedge aclk);
        cfg_we    = 1'b0;
        if (idx == CFG_LEFT_COUNT) left_set = val;
        else right_set = val;
    endtask

    task automatic run_graph(input int lc, input int rc);
        int                  order [RowSlots];
        int                  i;
        int                  j;
        int                  tmp;
        int                  mode;
        logic [RowSlots-1:0] need;
        mode = $urandom_range(0, 6);
        need = (lc >= RowSlots) ? '1 : ((32'd1 << lc) - 32'd1);
        if ((rows_written & need) == need && $urandom_range(0, 4) == 0) begin
            // partial reload on top of rows left from earlier runs
            repeat ($urandom_range(0, 3)) begin
                i = $urandom_range(0, 31);
                send_row(i[VertW-1:0], row_pattern(mode, i, rc), 1'b0);
            end
            i = $urandom_range(0, 31);
            send_row(i[VertW-1:0], row_pattern(mode, i, rc), 1'b1);
        end else if (lc == 0) begin
            i = $urandom_range(0, 31);
            send_row(i[VertW-1:0], row_pattern(mode, i, rc), 1'b1);
        end else begin
            for (i = 0; i < lc; i++) order[i] = i;
            for (i = lc - 1; i > 0; i--) begin
                j = $urandom_range(0, i);
                tmp = order[i];
                order[i] = order[j];
                order[j] = tmp;
            end
            for (i = 0; i < lc; i++) begin
                if ($urandom_range(0, 7) == 0) begin
                    j = (lc < RowSlots) ? $urandom_range(lc, 31) : $urandom_range(0, 31);
                    send_row(j[VertW-1:0], row_pattern(mode, j, rc), 1'b0);
                end
                send_row(order[i][VertW-1:0], row_pattern(mode, order[i], rc), i == lc - 1);
            end
        end
    endtask

    initial begin
        int   start_items;
        int   phase;
        int   k;
        int   sel;
        int   runs;
        logic [CfgW-1:0] lv;
        logic [CfgW-1:0] rv;
        aresetn      = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tlast      = 1'b0;
        cfg_we       = 1'b0;
        cfg_index    = CFG_LEFT_COUNT;
        cfg_wdata    = '0;
        items_sent   = 0;
        burst_left   = 0;
        rows_written = '0;
        left_set     = 6'd32;
        right_set    = 6'd32;
        repeat (4) @(negedge aclk);
        aresetn = 1'b1;

        // small graph: displacement along a path, high columns ignored, row past L
        write_count(CFG_LEFT_COUNT, 6'd3);
        write_count(CFG_RIGHT_COUNT, 6'd4);
        send_row(5'd0, 32'hFFFF_FFFF, 1'b0);
        send_row(5'd31, 32'hFFFF_FFFF, 1'b0);
        send_row(5'd1, 32'h0000_0001, 1'b0);
        send_row(5'd2, 32'h0000_0001, 1'b1);
        send_row(5'd0, 32'h0000_0001, 1'b0);
        send_row(5'd1, 32'h0000_0003, 1'b0);
        send_row(5'd2, 32'h8000_0006, 1'b1);
        // no edges at all
        send_row(5'd0, 32'h0000_0000, 1'b0);
        send_row(5'd1, 32'h0000_0000, 1'b0);
        send_row(5'd2, 32'h0000_0000, 1'b1);
        // deep search stack, every left vertex matched
        drain_block();
        write_count(CFG_LEFT_COUNT, 6'd4);
        send_row(5'd0, 32'h0000_0003, 1'b0);
        send_row(5'd1, 32'h0000_0001, 1'b0);
        send_row(5'd2, 32'h0000_0006, 1'b0);
        send_row(5'd3, 32'h0000_000C, 1'b1);
        // no left vertices
        drain_block();
        write_count(CFG_LEFT_COUNT, 6'd0);
        send_row(5'd5, $urandom, 1'b1);
        // single vertex each side
        drain_block();
        write_count(CFG_LEFT_COUNT, 6'd1);
        write_count(CFG_RIGHT_COUNT, 6'd1);
        send_row(5'd0, 32'h0000_0001, 1'b1);
        send_row(5'd0, 32'hFFFF_FFFE, 1'b1);
        // no right vertices: run produces no words
        drain_block();
        write_count(CFG_RIGHT_COUNT, 6'd0);
        send_row(5'd0, 32'h0000_0001, 1'b1);

        start_items = items_sent;
        phase = 0;
        while (items_sent - start_items < ItemTarget) begin
            sel = 0;
            if (phase == 0) begin
                lv = 6'd63;
                rv = 6'd32;
            end else if (phase == 1) begin
                lv = 6'd32;
                rv = 6'd63;
            end else begin
                sel = $urandom_range(0, 2);
                k = $urandom_range(0, 19);
                if (k == 0) begin
                    lv = ($urandom_range(0, 1)) ? 6'd32 : 6'(($urandom_range(0, 1)) ? 40 : 63);
                    rv = ($urandom_range(0, 1)) ? 6'd32 : 6'(($urandom_range(0, 1)) ? 50 : 63);
                end else if (k == 1) begin
                    if ($urandom_range(0, 1)) begin
                        lv = 6'd0;
                        rv = 6'($urandom_range(1, 8));
                    end else begin
                        lv = 6'($urandom_range(1, 8));
                        rv = 6'd0;
                    end
                end else if (k < 6) begin
                    lv = 6'($urandom_range(9, 24));
                    rv = 6'($urandom_range(9, 24));
                end else begin
                    lv = 6'($urandom_range(1, 8));
                    rv = 6'($urandom_range(1, 8));
                end
            end
            drain_block();
            if (sel != 2) write_count(CFG_LEFT_COUNT, lv);
            if (sel != 1) write_count(CFG_RIGHT_COUNT, rv);
            runs = (clamp_count(left_set) >= 20) ? 1 : $urandom_range(1, 4);
            repeat (runs) run_graph(clamp_count(left_set), clamp_count(right_set));
            phase++;
        end

        drain_block();
        if (fail_count == 0) begin
            $display("bipartite_maximum_matching_top: match");
        end else begin
            $display("bipartite_maximum_matching_top: mismatch");
        end
        $finish;
    end

endmodule

[files.f]
rtl/bmm_pkg.sv
rtl/bmm_ctrl.sv
rtl/bmm_dp.sv
rtl/bipartite_maximum_matching_top.sv
test/bmm_pairing_checker.sv
test/bipartite_maximum_matching_top_tb.sv
